// ===== src/dag_shortest_path_engine_top_assert.svh =====
// ----------------------------------------------------------------------------
// dag shortest path engine assertion macros
// implication forms used by the top level checks
// ----------------------------------------------------------------------------
`ifndef DAG_SHORTEST_PATH_ENGINE_TOP_ASSERT_SVH
`define DAG_SHORTEST_PATH_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define DSP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DSP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/dsp_pkg.sv =====
// ----------------------------------------------------------------------------
// dsp_pkg
// shared types and constants of the dag shortest path engine
// ----------------------------------------------------------------------------
`default_nettype none

package dsp_pkg;

	localparam int NCW = 7;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_SOLVE = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ADD_WR,
		ST_ADD_LINK,
		ST_ERR_EM,
		ST_CLEAR,
		ST_ROOT,
		ST_PUSH,
		ST_TOP_RD,
		ST_TOP_EV,
		ST_EDGE_EV,
		ST_RX_NEXT,
		ST_RX_T,
		ST_RX_H,
		ST_RX_E,
		ST_RX_E2,
		ST_RX_E3,
		ST_OUT_RD,
		ST_OUT_EM
	} state_t;

	typedef enum logic [4:0] {
		CMD_IDLE,
		CMD_ADD_WR,
		CMD_ADD_LINK,
		CMD_ERR_EM,
		CMD_CLEAR,
		CMD_ROOT,
		CMD_PUSH,
		CMD_TOP_RD,
		CMD_TOP_EV,
		CMD_EDGE_EV,
		CMD_RX_NEXT,
		CMD_RX_T,
		CMD_RX_H,
		CMD_RX_E,
		CMD_RX_E2,
		CMD_RX_E3,
		CMD_OUT_RD,
		CMD_OUT_EM
	} op_t;

	typedef struct packed {
		op_t  op;
		logic fire;
	} cmd_t;

	typedef struct packed {
		logic acc_err;
		logic acc_solve;
		logic root_end;
		logic root_seen;
		logic cur_null;
		logic sp_last;
		logic push_ok;
		logic k_zero;
		logic t_reached;
		logic head_null;
		logic next_null;
		logic j_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ===== src/dag_shortest_path_engine_top.sv =====
// ----------------------------------------------------------------------------
// dag_shortest_path_engine_top
// Edges are loaded one request at a time and appended to the tail node's list
// in arrival order; an add-edge request returns one status result. A solve
// request with a start node in range runs a depth-first topological walk over
// nodes 0 to node_count-1, with node_count taken as 1 when zero and as
// MAX_NODES when larger, relaxes edges in reverse finishing order from the
// source, then returns one distance result per node with last on the final
// one; a start node out of range returns one status result instead. The walk
// and the relaxation read the edge, list and distance memories in turn.
// The user must write node_count only while the block is idle; the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module dag_shortest_path_engine_top
	import dsp_pkg::*;
#(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [NCW-1:0]     cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               opcode,
	input  wire logic [5:0]         from_node,
	input  wire logic [5:0]         to_node,
	input  wire logic signed [15:0] edge_weight,
	input  wire logic [5:0]         start_node,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [5:0]              node_id,
	output logic signed [31:0]      distance,
	output logic                    reachable,
	output logic [1:0]              status,
	output logic                    last
);

	`include "dag_shortest_path_engine_top_assert.svh"

	cmd_t  cmd;
	stat_t stat;

	dsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dsp_datapath #(
		.MAX_NODES (MAX_NODES),
		.MAX_EDGES (MAX_EDGES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.stat        (stat),
		.opcode      (opcode),
		.from_node   (from_node),
		.to_node     (to_node),
		.edge_weight (edge_weight),
		.start_node  (start_node),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.node_id     (node_id),
		.distance    (distance),
		.reachable   (reachable),
		.status      (status),
		.last        (last)
	);

	`DSP_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
	`DSP_ASSERT_NXT(a_emit_loads_out, (cmd.op == CMD_OUT_EM) && stat.out_free, out_valid, "result lost")
	`DSP_ASSERT_IMP(a_reach_ok, out_valid && reachable, status == STATUS_OK, "reachable with error")

endmodule

`default_nettype wire

// ===== src/dsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsp_ctrl
// sequencer for edge loading, depth-first walk, relaxation and readout
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_ctrl
	import dsp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd.fire = 1'b0;
		cmd.op   = CMD_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.op   = CMD_IDLE;
				if (in_valid) begin
					cmd.fire = 1'b1;
					if (stat.acc_err) state_d = ST_ERR_EM;
					else if (stat.acc_solve) state_d = ST_CLEAR;
					else state_d = ST_ADD_WR;
				end
			end
			ST_ADD_WR: begin
				cmd.op  = CMD_ADD_WR;
				state_d = ST_ADD_LINK;
			end
			ST_ADD_LINK: begin
				cmd.op = CMD_ADD_LINK;
				if (stat.out_free) state_d = ST_IDLE;
			end
			ST_ERR_EM: begin
				cmd.op = CMD_ERR_EM;
				if (stat.out_free) state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				cmd.op  = CMD_CLEAR;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.op = CMD_ROOT;
				if (stat.root_end) state_d = ST_RX_NEXT;
				else if (!stat.root_seen) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				cmd.op  = CMD_PUSH;
				state_d = ST_TOP_RD;
			end
			ST_TOP_RD: begin
				cmd.op  = CMD_TOP_RD;
				state_d = ST_TOP_EV;
			end
			ST_TOP_EV: begin
				cmd.op = CMD_TOP_EV;
				if (!stat.cur_null) state_d = ST_EDGE_EV;
				else if (stat.sp_last) state_d = ST_ROOT;
				else state_d = ST_TOP_RD;
			end
			ST_EDGE_EV: begin
				cmd.op  = CMD_EDGE_EV;
				state_d = stat.push_ok ? ST_PUSH : ST_TOP_RD;
			end
			ST_RX_NEXT: begin
				cmd.op  = CMD_RX_NEXT;
				state_d = stat.k_zero ? ST_OUT_RD : ST_RX_T;
			end
			ST_RX_T: begin
				cmd.op  = CMD_RX_T;
				state_d = stat.t_reached ? ST_RX_H : ST_RX_NEXT;
			end
			ST_RX_H: begin
				cmd.op  = CMD_RX_H;
				state_d = stat.head_null ? ST_RX_NEXT : ST_RX_E;
			end
			ST_RX_E: begin
				cmd.op  = CMD_RX_E;
				state_d = ST_RX_E2;
			end
			ST_RX_E2: begin
				cmd.op  = CMD_RX_E2;
				state_d = ST_RX_E3;
			end
			ST_RX_E3: begin
				cmd.op  = CMD_RX_E3;
				state_d = stat.next_null ? ST_RX_NEXT : ST_RX_E;
			end
			ST_OUT_RD: begin
				cmd.op  = CMD_OUT_RD;
				state_d = ST_OUT_EM;
			end
			ST_OUT_EM: begin
				cmd.op = CMD_OUT_EM;
				if (stat.out_free) state_d = stat.j_last ? ST_IDLE : ST_OUT_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/dsp_datapath.sv =====
// ----------------------------------------------------------------------------
// dsp_datapath
// edge store, list pointers, walk stack, distance memory and result register
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_datapath
	import dsp_pkg::*;
#(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [NCW-1:0]     cfg_wr_data,
	input  wire cmd_t               cmd,
	output stat_t                   stat,
	input  wire logic               opcode,
	input  wire logic [5:0]         from_node,
	input  wire logic [5:0]         to_node,
	input  wire logic signed [15:0] edge_weight,
	input  wire logic [5:0]         start_node,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [5:0]              node_id,
	output logic signed [31:0]      distance,
	output logic                    reachable,
	output logic [1:0]              status,
	output logic                    last
);

	localparam int NW  = $clog2(MAX_NODES);
	localparam int CW  = $clog2(MAX_NODES + 1);
	localparam int EAW = $clog2(MAX_EDGES);
	localparam int LW  = $clog2(MAX_EDGES + 1);
	localparam logic [LW-1:0]  NO_LINK = LW'(MAX_EDGES);
	localparam logic [NCW-1:0] N_MAX   = NCW'(MAX_NODES);
	localparam logic [CW-1:0]  SP_MAX  = CW'(MAX_NODES);

	// configuration and latched request
	logic [NCW-1:0]     nc_q;
	logic [NCW-1:0]     n_act;
	logic [NW-1:0]      u_q;
	logic [5:0]         v_q;
	logic signed [15:0] w_q;
	logic [NW-1:0]      src_q;
	logic [1:0]         err_q;
	logic [1:0]         acc_err_code;

	// counters and working registers
	logic [LW-1:0]  used_q;
	logic [EAW-1:0] e_q;
	logic [NCW-1:0] i_q;
	logic [NCW-1:0] j_q;
	logic [CW-1:0]  sp_q;
	logic [CW-1:0]  done_q;
	logic [CW-1:0]  k_q;
	logic [LW-1:0]  cur_q;
	logic signed [31:0] dt_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [MAX_NODES-1:0] reached_q;
	logic [MAX_NODES-1:0] nvld_q;

	// memories
	logic [5:0]    tgt_mem  [MAX_EDGES];
	logic [15:0]   cost_mem [MAX_EDGES];
	logic [LW-1:0] next_mem [MAX_EDGES];
	logic [LW-1:0] head_mem [MAX_NODES];
	logic [LW-1:0] tail_mem [MAX_NODES];
	logic [NW-1:0] stkn_mem [MAX_NODES];
	logic [LW-1:0] stkc_mem [MAX_NODES];
	logic [NW-1:0] topo_mem [MAX_NODES];
	logic [31:0]   best_mem [MAX_NODES];

	logic [5:0]         tgt_rd;
	logic signed [15:0] cost_rd;
	logic [LW-1:0]      next_rd;
	logic [LW-1:0]      head_rd;
	logic               head_v;
	logic [LW-1:0]      tail_rd;
	logic               tail_v;
	logic [NW-1:0]      stkn_rd;
	logic [LW-1:0]      stkc_rd;
	logic [NW-1:0]      topo_rd;
	logic signed [31:0] best_rd;

	// memory controls
	logic           e_we;
	logic           nx_we;
	logic [EAW-1:0] nx_waddr;
	logic [LW-1:0]  nx_wdata;
	logic           er_en;
	logic [EAW-1:0] er_addr;
	logic           hd_en;
	logic [NW-1:0]  hd_addr;
	logic           sn_we;
	logic [NW-1:0]  sn_waddr;
	logic [NW-1:0]  sn_wdata;
	logic           sc_we;
	logic [NW-1:0]  sc_waddr;
	logic [LW-1:0]  sc_wdata;
	logic           stk_re;
	logic           tp_we;
	logic           tp_re;
	logic           bw_en;
	logic [NW-1:0]  bw_addr;
	logic [31:0]    bw_data;
	logic           br_en;
	logic [NW-1:0]  br_addr;

	// derived values
	logic [LW-1:0]      head_val;
	logic [NW-1:0]      top_idx;
	logic [NW-1:0]      nb;
	logic [NW-1:0]      hd_node;
	logic signed [32:0] sum;
	logic signed [31:0] cand;
	logic               better;
	logic               out_free;
	logic               emit;

	always_comb begin
		n_act = nc_q;
		if (nc_q == '0) n_act = NCW'(1);
		else if (nc_q > N_MAX) n_act = N_MAX;
	end

	always_comb begin
		acc_err_code = STATUS_OK;
		if (opcode == OP_SOLVE) begin
			if ({1'b0, start_node} >= n_act) acc_err_code = STATUS_RANGE;
		end else if ({1'b0, from_node} >= n_act || {1'b0, to_node} >= n_act) begin
			acc_err_code = STATUS_RANGE;
		end else if (used_q == NO_LINK) begin
			acc_err_code = STATUS_FULL;
		end
	end

	assign head_val = head_v ? head_rd : NO_LINK;
	assign top_idx  = NW'(sp_q - CW'(1));
	assign nb       = tgt_rd[NW-1:0];
	assign hd_node  = tgt_rd[NW-1:0];
	assign sum      = {dt_q[31], dt_q} + 33'(cost_rd);
	assign out_free = !out_valid || out_ready;

	always_comb begin
		cand = sum[31:0];
		if (sum[32] != sum[31]) cand = sum[32] ? INT_MIN : INT_MAX;
	end

	assign better = !reached_q[hd_node] || (cand < best_rd);

	always_comb begin
		stat.acc_err   = (acc_err_code != STATUS_OK);
		stat.acc_solve = (opcode == OP_SOLVE);
		stat.root_end  = (i_q == n_act);
		stat.root_seen = visited_q[i_q[NW-1:0]];
		stat.cur_null  = (stkc_rd == NO_LINK);
		stat.sp_last   = (sp_q == CW'(1));
		stat.push_ok   = !visited_q[nb] && (sp_q < SP_MAX);
		stat.k_zero    = (k_q == '0);
		stat.t_reached = reached_q[topo_rd];
		stat.head_null = (head_val == NO_LINK);
		stat.next_null = (next_rd == NO_LINK);
		stat.j_last    = (j_q + NCW'(1) == n_act);
		stat.out_free  = out_free;
	end

	always_comb begin
		e_we     = 1'b0;
		nx_we    = 1'b0;
		nx_waddr = e_q;
		nx_wdata = NO_LINK;
		er_en    = 1'b0;
		er_addr  = cur_q[EAW-1:0];
		hd_en    = 1'b0;
		hd_addr  = i_q[NW-1:0];
		sn_we    = 1'b0;
		sn_waddr = sp_q[NW-1:0];
		sn_wdata = i_q[NW-1:0];
		sc_we    = 1'b0;
		sc_waddr = sp_q[NW-1:0];
		sc_wdata = head_val;
		stk_re   = 1'b0;
		tp_we    = 1'b0;
		tp_re    = 1'b0;
		bw_en    = 1'b0;
		bw_addr  = src_q;
		bw_data  = '0;
		br_en    = 1'b0;
		br_addr  = topo_rd;
		emit     = 1'b0;
		unique case (cmd.op)
			CMD_ADD_WR: begin
				e_we = 1'b1;
				nx_we = 1'b1;
			end
			CMD_ADD_LINK: begin
				nx_we    = tail_v;
				nx_waddr = tail_rd[EAW-1:0];
				nx_wdata = LW'(e_q);
				emit     = out_free;
			end
			CMD_ERR_EM: begin
				emit = out_free;
			end
			CMD_CLEAR: begin
				bw_en = 1'b1;
			end
			CMD_ROOT: begin
				if (!stat.root_end && !stat.root_seen) begin
					hd_en = 1'b1;
					sn_we = 1'b1;
				end
			end
			CMD_PUSH: begin
				sc_we = 1'b1;
			end
			CMD_TOP_RD: begin
				stk_re = 1'b1;
			end
			CMD_TOP_EV: begin
				if (!stat.cur_null) begin
					er_en   = 1'b1;
					er_addr = stkc_rd[EAW-1:0];
				end else begin
					tp_we = (done_q < SP_MAX);
				end
			end
			CMD_EDGE_EV: begin
				sc_we    = 1'b1;
				sc_waddr = top_idx;
				sc_wdata = next_rd;
				if (stat.push_ok) begin
					sn_we    = 1'b1;
					sn_wdata = nb;
					hd_en    = 1'b1;
					hd_addr  = nb;
				end
			end
			CMD_RX_NEXT: begin
				tp_re = !stat.k_zero;
			end
			CMD_RX_T: begin
				hd_en   = 1'b1;
				hd_addr = topo_rd;
				br_en   = 1'b1;
			end
			CMD_RX_E: begin
				er_en = 1'b1;
			end
			CMD_RX_E2: begin
				br_en   = 1'b1;
				br_addr = hd_node;
			end
			CMD_RX_E3: begin
				bw_en   = better;
				bw_addr = hd_node;
				bw_data = cand;
			end
			CMD_OUT_RD: begin
				br_en   = 1'b1;
				br_addr = j_q[NW-1:0];
			end
			CMD_OUT_EM: begin
				emit = out_free;
			end
			default: begin
			end
		endcase
	end

	// edge store
	always_ff @(posedge clk) begin
		if (e_we) begin
			tgt_mem[e_q]  <= v_q;
			cost_mem[e_q] <= w_q;
		end
		if (nx_we) next_mem[nx_waddr] <= nx_wdata;
		if (er_en) begin
			tgt_rd  <= tgt_mem[er_addr];
			cost_rd <= cost_mem[er_addr];
			next_rd <= next_mem[er_addr];
		end
	end

	// list pointers
	always_ff @(posedge clk) begin
		if (cmd.op == CMD_ADD_WR) begin
			tail_mem[u_q] <= LW'(e_q);
			if (!tail_v) head_mem[u_q] <= LW'(e_q);
		end
		if (cmd.fire) begin
			tail_rd <= tail_mem[from_node[NW-1:0]];
			tail_v  <= nvld_q[from_node[NW-1:0]];
		end
		if (hd_en) begin
			head_rd <= head_mem[hd_addr];
			head_v  <= nvld_q[hd_addr];
		end
	end

	// walk stack, finishing order and distances
	always_ff @(posedge clk) begin
		if (sn_we) stkn_mem[sn_waddr] <= sn_wdata;
		if (sc_we) stkc_mem[sc_waddr] <= sc_wdata;
		if (stk_re) begin
			stkn_rd <= stkn_mem[top_idx];
			stkc_rd <= stkc_mem[top_idx];
		end
		if (tp_we) topo_mem[done_q[NW-1:0]] <= stkn_rd;
		if (tp_re) topo_rd <= topo_mem[NW'(k_q - CW'(1))];
		if (bw_en) best_mem[bw_addr] <= bw_data;
		if (br_en) best_rd <= best_mem[br_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			u_q   <= from_node[NW-1:0];
			v_q   <= to_node;
			w_q   <= edge_weight;
			src_q <= start_node[NW-1:0];
			err_q <= acc_err_code;
			e_q   <= used_q[EAW-1:0];
		end
		if (cmd.op == CMD_RX_H) begin
			dt_q  <= best_rd;
			cur_q <= head_val;
		end
		if (cmd.op == CMD_RX_E3) begin
			cur_q <= next_rd;
			if (better && hd_node == topo_rd) dt_q <= cand;
		end
		if (emit) begin
			if (cmd.op == CMD_OUT_EM) begin
				node_id   <= 6'(j_q);
				distance  <= reached_q[j_q[NW-1:0]] ? best_rd : '0;
				reachable <= reached_q[j_q[NW-1:0]];
				status    <= STATUS_OK;
				last      <= stat.j_last;
			end else begin
				node_id   <= '0;
				distance  <= '0;
				reachable <= 1'b0;
				status    <= (cmd.op == CMD_ERR_EM) ? err_q : STATUS_OK;
				last      <= 1'b1;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q      <= NCW'(64);
			used_q    <= '0;
			nvld_q    <= '0;
			visited_q <= '0;
			reached_q <= '0;
			i_q       <= '0;
			j_q       <= '0;
			sp_q      <= '0;
			done_q    <= '0;
			k_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_wr_en) nc_q <= cfg_wr_data;
			if (emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (cmd.op)
				CMD_ADD_WR: begin
					used_q     <= used_q + LW'(1);
					nvld_q[u_q] <= 1'b1;
				end
				CMD_CLEAR: begin
					visited_q <= '0;
					reached_q <= MAX_NODES'(1) << src_q;
					i_q       <= '0;
					sp_q      <= '0;
					done_q    <= '0;
				end
				CMD_ROOT: begin
					if (stat.root_end) k_q <= done_q;
					else if (stat.root_seen) i_q <= i_q + NCW'(1);
					else visited_q[i_q[NW-1:0]] <= 1'b1;
				end
				CMD_PUSH: begin
					sp_q <= sp_q + CW'(1);
				end
				CMD_TOP_EV: begin
					if (stat.cur_null) begin
						if (done_q < SP_MAX) done_q <= done_q + CW'(1);
						sp_q <= sp_q - CW'(1);
						if (stat.sp_last) i_q <= i_q + NCW'(1);
					end
				end
				CMD_EDGE_EV: begin
					if (stat.push_ok) visited_q[nb] <= 1'b1;
				end
				CMD_RX_NEXT: begin
					if (stat.k_zero) j_q <= '0;
					else k_q <= k_q - CW'(1);
				end
				CMD_RX_E3: begin
					if (better) reached_q[hd_node] <= 1'b1;
				end
				CMD_OUT_EM: begin
					if (out_free) j_q <= j_q + NCW'(1);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the dag shortest path engine: edge loads and solves are driven with
// random gaps on both channels, node_count is changed between phases, and
// every result is compared with a behavioral predictor of the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top
	import dsp_pkg::*;
();

	localparam int NODES = 64;
	localparam int EDGES = 256;
	localparam int NOLINK = EDGES;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic               opcode;
		logic [5:0]         from_node;
		logic [5:0]         to_node;
		logic signed [15:0] edge_weight;
		logic [5:0]         start_node;
	} request_t;

	typedef struct packed {
		logic [5:0]         node_id;
		logic signed [31:0] distance;
		logic               reachable;
		logic [1:0]         status;
		logic               last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [NCW-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	request_t req_bus = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	result_t res_bus;

	dag_shortest_path_engine_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(req_bus.opcode), .from_node(req_bus.from_node),
		.to_node(req_bus.to_node), .edge_weight(req_bus.edge_weight),
		.start_node(req_bus.start_node),
		.out_valid(out_valid), .out_ready(out_ready),
		.node_id(res_bus.node_id), .distance(res_bus.distance),
		.reachable(res_bus.reachable), .status(res_bus.status),
		.last(res_bus.last)
	);

	// predictor state
	int unsigned node_cnt = 64;
	logic [5:0] e_to [EDGES];
	int e_cost [EDGES];
	int e_next [EDGES];
	int l_head [NODES];
	int l_tail [NODES];
	int n_edges = 0;

	request_t pending_q[$];
	result_t expected_q[$];
	int errors = 0;
	int queued = 0;
	int sent = 0;
	int got = 0;
	int solves = 0;
	int snd_idle = 16;
	int rcv_idle = 81;
	int stall = 0;

	task automatic report(input string what, input result_t g, input result_t e);
		errors++;
		$display("error %s: got id=%0d d=%0d r=%0b s=%0d l=%0b exp id=%0d d=%0d r=%0b s=%0d l=%0b",
			what, g.node_id, g.distance, g.reachable, g.status, g.last,
			e.node_id, e.distance, e.reachable, e.status, e.last);
	endtask

	task automatic queue_req(input request_t q);
		pending_q = {pending_q, q};
		queued++;
	endtask

	task automatic expect_result(input result_t r);
		expected_q = {expected_q, r};
	endtask

	function automatic int unsigned active_count();
		int unsigned n;
		n = node_cnt;
		if (n < 1) n = 1;
		if (n > NODES) n = NODES;
		return n;
	endfunction

	function automatic result_t status_only(input logic [1:0] s);
		result_t r;
		r = '0;
		r.status = s;
		r.last = 1'b1;
		return r;
	endfunction

	task automatic predict_distances(input request_t q);
		int unsigned n;
		bit seen [NODES];
		bit hit [NODES];
		longint best [NODES];
		int order [NODES];
		int stk_node [NODES];
		int stk_cur [NODES];
		int done, sp, top, cur, nb, t, e, h;
		longint cand;
		result_t r;
		n = active_count();
		if (q.opcode == OP_ADD) begin
			if (q.from_node >= n || q.to_node >= n) expect_result(status_only(STATUS_RANGE));
			else if (n_edges >= EDGES) expect_result(status_only(STATUS_FULL));
			else begin
				e_to[n_edges] = q.to_node;
				e_cost[n_edges] = q.edge_weight;
				e_next[n_edges] = NOLINK;
				if (l_tail[q.from_node] < EDGES) e_next[l_tail[q.from_node]] = n_edges;
				else l_head[q.from_node] = n_edges;
				l_tail[q.from_node] = n_edges;
				n_edges++;
				expect_result(status_only(STATUS_OK));
			end
			return;
		end
		if (q.start_node >= n) begin
			expect_result(status_only(STATUS_RANGE));
			return;
		end
		for (int i = 0; i < NODES; i++) begin
			seen[i] = 0; hit[i] = 0; best[i] = 0;
		end
		done = 0;
		for (int root = 0; root < n; root++) begin
			if (seen[root]) continue;
			seen[root] = 1;
			stk_node[0] = root;
			stk_cur[0] = l_head[root];
			sp = 1;
			while (sp > 0) begin
				top = sp - 1;
				cur = stk_cur[top];
				if (cur < EDGES) begin
					nb = e_to[cur];
					stk_cur[top] = e_next[cur];
					if (!seen[nb] && sp < NODES) begin
						seen[nb] = 1;
						stk_node[sp] = nb;
						stk_cur[sp] = l_head[nb];
						sp++;
					end
				end else begin
					if (done < NODES) begin
						order[done] = stk_node[top];
						done++;
					end
					sp--;
				end
			end
		end
		hit[q.start_node] = 1;
		for (int k = done; k > 0; k--) begin
			t = order[k-1];
			if (!hit[t]) continue;
			for (e = l_head[t]; e < EDGES; e = e_next[e]) begin
				h = e_to[e];
				cand = best[t] + e_cost[e];
				if (cand > 64'sd2147483647) cand = 64'sd2147483647;
				if (cand < -64'sd2147483648) cand = -64'sd2147483648;
				if (!hit[h] || cand < best[h]) begin
					best[h] = cand;
					hit[h] = 1;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			r.node_id = 6'(i);
			r.reachable = hit[i];
			r.distance = hit[i] ? 32'(best[i]) : 32'sd0;
			r.status = STATUS_OK;
			r.last = (i + 1 == n);
			expect_result(r);
		end
	endtask

	function automatic request_t add_req(input int u, input int v, input int w);
		request_t q;
		q = '0;
		q.opcode = OP_ADD;
		q.from_node = 6'(u);
		q.to_node = 6'(v);
		q.edge_weight = 16'(w);
		return q;
	endfunction

	function automatic request_t solve_req(input int s);
		request_t q;
		q = '0;
		q.opcode = OP_SOLVE;
		q.from_node = 6'($urandom);
		q.to_node = 6'($urandom);
		q.edge_weight = 16'($urandom);
		q.start_node = 6'(s);
		return q;
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			predict_distances(req_bus);
			sent++;
		end
		if (!in_valid || in_ready) begin
			if (pending_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
				in_valid <= 1'b1;
				req_bus <= pending_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t e;
		if (out_valid && out_ready) begin
			got++;
			if (expected_q.size() == 0) begin
				report("unexpected result", res_bus, '0);
			end else begin
				e = expected_q.pop_front();
				if (res_bus.node_id !== e.node_id) report("node_id", res_bus, e);
				else if (res_bus.distance !== e.distance) report("distance", res_bus, e);
				else if (res_bus.reachable !== e.reachable) report("reachable", res_bus, e);
				else if (res_bus.status !== e.status) report("status", res_bus, e);
				else if (res_bus.last !== e.last) report("last", res_bus, e);
			end
		end
		out_ready <= ($urandom_range(99) >= rcv_idle);
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) stall <= 0;
		else stall <= stall + 1;
		if (stall >= STALL_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_q.size());
			$display("dag_shortest_path_engine_top: mismatch");
			$finish;
		end
	end

	task automatic drain();
		while (sent != queued || expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_nodes(input int unsigned v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= NCW'(v);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		node_cnt = v;
	endtask

	task automatic random_phase(input int count, input int unsigned span);
		int u;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0) begin
				queue_req(solve_req($urandom_range(span)));
				solves++;
			end else if ($urandom_range(19) == 0) begin
				queue_req(add_req($urandom, $urandom, $urandom));
			end else begin
				// mostly forward edges, some back edges for cycles
				u = $urandom_range(span - 1);
				queue_req(add_req(u, ($urandom_range(5) == 0) ?
					$urandom_range(span - 1) : $urandom_range(span - 1, u),
					$urandom));
			end
		end
	endtask

	initial begin
		for (int i = 0; i < NODES; i++) begin
			l_head[i] = NOLINK;
			l_tail[i] = NOLINK;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, range errors, cycle, solves
		set_nodes(8);
		queue_req(add_req(0, 1, 32767));
		queue_req(add_req(1, 2, -32768));
		queue_req(add_req(0, 2, 5));
		queue_req(add_req(2, 0, 3));
		queue_req(add_req(7, 7, -1));
		queue_req(add_req(8, 1, 1));
		queue_req(add_req(1, 63, 1));
		queue_req(add_req(63, 63, 0));
		queue_req(add_req(3, 4, 0));
		queue_req(solve_req(0));
		queue_req(solve_req(7));
		queue_req(solve_req(8));
		queue_req(solve_req(63));
		queue_req(solve_req(3));
		drain();
		set_nodes(1);
		queue_req(solve_req(0));
		queue_req(solve_req(1));
		queue_req(add_req(0, 0, -7));
		queue_req(solve_req(0));
		drain();
		set_nodes(0);
		queue_req(solve_req(0));
		drain();

		set_nodes(16);
		random_phase(100, 16);
		drain();
		snd_idle = 81;
		rcv_idle = 16;
		set_nodes(127);
		random_phase(110, 63);
		drain();
		snd_idle = 0;
		rcv_idle = 0;
		set_nodes(64);
		random_phase(80, 63);
		// store now full
		queue_req(add_req(0, 1, 1));
		queue_req(add_req(2, 3, -1));
		queue_req(solve_req(0));
		drain();
		set_nodes(5);
		queue_req(solve_req(0));
		queue_req(solve_req(4));
		drain();

		$display("%0d requests (%0d solves), %0d results checked, %0d edges stored",
			sent, solves, got, n_edges);
		if (errors == 0) $display("dag_shortest_path_engine_top: match");
		else $display("dag_shortest_path_engine_top: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
